/* hw/rtl/tlcm_pkg.sv */
package tlcm_pkg;

  // reset value of the parallel threshold, units of 2^-56 (about 1e-10)
  localparam logic [31:0] THRESHOLD_RESET = 32'd7205759;

  localparam int PW   = 32;            // position field
  localparam int DW   = 16;            // direction field
  localparam int WW   = PW + 1;        // P1-P2, P1+P2
  localparam int AW   = 2 * DW + 2;    // a, b, c
  localparam int DEW  = DW + WW + 2;   // d, e
  localparam int CW   = 2 * DW + 1;    // cross product terms
  localparam int DENW = 64;            // denominator
  localparam int NW   = 86;            // n1, n2, parallel numerator
  localparam int NUMW = NW + DW;       // numerator of one offset
  localparam int MAGW = NUMW - 1;      // its magnitude
  localparam int QB   = 40;            // quotient bits before clamping
  localparam int QW   = QB + 1;        // rounded quotient magnitude
  localparam int OFW  = QB + 2;        // signed offset
  localparam int SW   = 44;            // P1 + P2 + both offsets

  // divider: head stage, one stage per quotient bit, rounding stage
  localparam int DIV_LAT = QB + 2;
  localparam int PRE_ST  = 10;
  localparam int POST_ST = 4;
  localparam int N_ST    = PRE_ST + DIV_LAT + POST_ST;

endpackage

/* hw/rtl/two_line_closest_midpoint_core.sv */
// Midpoint of the segment of closest approach between two 3D lines, each
// given as a point (signed Q23.8) and a direction (signed Q1.14, any length).
// One result per transfer, in order. The pipeline takes a new line pair every
// cycle while mid_stall does not hold it. Ten stages of dot products and
// 2x2 solve feed the six-lane divider (one quotient bit per stage, 40 bits
// plus head and rounding stages), followed by four stages of summing,
// halving and clipping. When a result is waiting, mid_stall freezes the
// whole pipeline, so pair_stall follows it; bubbles stay in place.
// Arithmetic is exact integer up to the final divisions, which round
// to nearest, ties away from zero. When |D1 x D2|^2 is below
// threshold (or zero) the lines count as parallel: s = 0, t = -d/a, and
// lines_parallel is set. A zero first direction forces t = 0 and sets
// zero_direction. Offsets whose quotient exceeds 2^40 are clipped there.
// The threshold register may only be written while no transfer is in flight.
module two_line_closest_midpoint_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         threshold_we,
  input  logic [31:0]                  threshold_data,
  input  logic                         pair_valid,
  output logic                         pair_stall,
  input  logic signed [tlcm_pkg::PW-1:0] first_point_x,
  input  logic signed [tlcm_pkg::PW-1:0] first_point_y,
  input  logic signed [tlcm_pkg::PW-1:0] first_point_z,
  input  logic signed [tlcm_pkg::DW-1:0] first_dir_x,
  input  logic signed [tlcm_pkg::DW-1:0] first_dir_y,
  input  logic signed [tlcm_pkg::DW-1:0] first_dir_z,
  input  logic signed [tlcm_pkg::PW-1:0] second_point_x,
  input  logic signed [tlcm_pkg::PW-1:0] second_point_y,
  input  logic signed [tlcm_pkg::PW-1:0] second_point_z,
  input  logic signed [tlcm_pkg::DW-1:0] second_dir_x,
  input  logic signed [tlcm_pkg::DW-1:0] second_dir_y,
  input  logic signed [tlcm_pkg::DW-1:0] second_dir_z,
  output logic                         mid_valid,
  input  logic                         mid_stall,
  output logic signed [tlcm_pkg::PW-1:0] mid_x,
  output logic signed [tlcm_pkg::PW-1:0] mid_y,
  output logic signed [tlcm_pkg::PW-1:0] mid_z,
  output logic                         lines_parallel,
  output logic                         zero_direction,
  output logic                         saturated
);
  import tlcm_pkg::*;

  // split points for the wide products
  localparam int LOW  = 26;                 // d, e split
  localparam int PPW  = LOW + 1 + AW;       // d/e partial product
  localparam int HLO  = 29;                 // numerator split
  localparam int HPW  = HLO + 1 + DW;       // numerator partial product

  typedef struct packed {
    logic [2:0][WW-1:0] ps;
    logic               par;
    logic               zd;
  } side_t;

  logic              adv;
  logic [N_ST-1:0]   vld;
  logic [31:0]       thr;

  logic signed [PW-1:0] in_p1 [3];
  logic signed [PW-1:0] in_p2 [3];
  logic signed [DW-1:0] in_d1 [3];
  logic signed [DW-1:0] in_d2 [3];

  // stage A: differences and sums of points
  logic signed [DW-1:0] sa_d1 [3];
  logic signed [DW-1:0] sa_d2 [3];
  logic signed [WW-1:0] sa_w0 [3];
  logic [2:0][WW-1:0]   sa_ps;
  // stage B: products
  logic signed [DW-1:0]      sb_d1 [3];
  logic signed [DW-1:0]      sb_d2 [3];
  logic [2:0][WW-1:0]        sb_ps;
  logic signed [2*DW-1:0]    sb_aa [3];
  logic signed [2*DW-1:0]    sb_bb [3];
  logic signed [2*DW-1:0]    sb_cc [3];
  logic signed [DW+WW-1:0]   sb_dd [3];
  logic signed [DW+WW-1:0]   sb_ee [3];
  logic signed [2*DW-1:0]    sb_m  [6];
  // stage C: dot products and cross product
  logic signed [DW-1:0]  sc_d1 [3];
  logic signed [DW-1:0]  sc_d2 [3];
  logic [2:0][WW-1:0]    sc_ps;
  logic signed [AW-1:0]  sc_a, sc_b, sc_c;
  logic signed [DEW-1:0] sc_d, sc_e;
  logic signed [CW-1:0]  sc_cr [3];
  // stage D: squares and partial products of the solve
  logic signed [DW-1:0]  sd_d1 [3];
  logic signed [DW-1:0]  sd_d2 [3];
  logic [2:0][WW-1:0]    sd_ps;
  logic [DENW-1:0]       sd_sq [3];
  logic signed [PPW-1:0] sd_pp [8];
  logic signed [AW-1:0]  sd_a;
  logic signed [DEW-1:0] sd_d;
  logic                  sd_zd;
  // stage E
  logic signed [DW-1:0]  se_d1 [3];
  logic signed [DW-1:0]  se_d2 [3];
  logic [2:0][WW-1:0]    se_ps;
  logic [DENW-1:0]       se_denom;
  logic signed [NW-1:0]  se_eb, se_dc, se_ea, se_db;
  logic signed [AW-1:0]  se_a;
  logic signed [DEW-1:0] se_d;
  logic                  se_zd;
  // stage F
  logic signed [DW-1:0]  sf_d1 [3];
  logic signed [DW-1:0]  sf_d2 [3];
  logic [2:0][WW-1:0]    sf_ps;
  logic [DENW-1:0]       sf_denom;
  logic signed [NW-1:0]  sf_n1, sf_n2;
  logic signed [AW-1:0]  sf_a;
  logic signed [DEW-1:0] sf_d;
  logic                  sf_zd, sf_par;
  // stage G: branch select
  logic signed [DW-1:0]  sg_d1 [3];
  logic signed [DW-1:0]  sg_d2 [3];
  logic [2:0][WW-1:0]    sg_ps;
  logic signed [NW-1:0]  sg_x, sg_y;
  logic [DENW-1:0]       sg_den;
  logic                  sg_zd, sg_par;
  // stage H: numerator partials, lanes 0..2 on D1, 3..5 on D2
  logic signed [HPW-1:0] sh_pp [6][3];
  logic [DENW-1:0]       sh_den;
  logic [2:0][WW-1:0]    sh_ps;
  logic                  sh_zd, sh_par;
  // stage I
  logic signed [NUMW-1:0] si_num [6];
  logic [DENW-1:0]        si_den;
  logic [2:0][WW-1:0]     si_ps;
  logic                   si_zd, si_par;
  // stage J
  logic [MAGW-1:0]        sj_mag [6];
  logic                   sj_neg [6];
  logic [DENW-1:0]        sj_den;
  side_t                  sj_side;
  // divider and side delay
  logic [QW-1:0]          q_mag [6];
  logic                   q_neg [6];
  side_t                  dly [DIV_LAT];
  // post stages
  logic signed [OFW-1:0]  r1_off [6];
  side_t                  r1_side;
  logic signed [SW-1:0]   r2_sum [3];
  logic                   r2_par, r2_zd;
  logic [SW-1:0]          r3_mag [3];
  logic                   r3_neg [3];
  logic                   r3_par, r3_zd;
  logic [SW-1:0]          r4_h [3];
  logic                   r4_over [3];
  logic signed [PW-1:0]   r4_val [3];

  function automatic logic signed [PPW-1:0] mul_lo(input logic [LOW-1:0] x,
                                                   input logic signed [AW-1:0] y);
    return PPW'(signed'({1'b0, x})) * PPW'(y);
  endfunction

  function automatic logic signed [PPW-1:0] mul_hi(input logic signed [DEW-LOW-1:0] x,
                                                   input logic signed [AW-1:0] y);
    return PPW'(x) * PPW'(y);
  endfunction

  function automatic logic signed [NW-1:0] join_pp(input logic signed [PPW-1:0] hi,
                                                   input logic signed [PPW-1:0] lo);
    return (NW'(hi) <<< LOW) + NW'(lo);
  endfunction

  function automatic logic signed [HPW-1:0] mul_n(input logic signed [HLO:0] x,
                                                  input logic signed [DW-1:0] y);
    return HPW'(x) * HPW'(y);
  endfunction

  assign in_p1 = '{first_point_x, first_point_y, first_point_z};
  assign in_p2 = '{second_point_x, second_point_y, second_point_z};
  assign in_d1 = '{first_dir_x, first_dir_y, first_dir_z};
  assign in_d2 = '{second_dir_x, second_dir_y, second_dir_z};

  // whole pipeline holds while a finished result is not taken
  assign adv        = !(vld[N_ST-1] && mid_stall);
  assign pair_stall = !adv;
  assign mid_valid  = vld[N_ST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THRESHOLD_RESET;
    end else if (threshold_we) begin
      thr <= threshold_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[N_ST-2:0], pair_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // A
      for (int i = 0; i < 3; i++) begin
        sa_d1[i] <= in_d1[i];
        sa_d2[i] <= in_d2[i];
        sa_w0[i] <= WW'(in_p1[i]) - WW'(in_p2[i]);
        sa_ps[i] <= WW'(in_p1[i]) + WW'(in_p2[i]);
      end
      // B
      sb_d1 <= sa_d1;
      sb_d2 <= sa_d2;
      sb_ps <= sa_ps;
      for (int i = 0; i < 3; i++) begin
        sb_aa[i] <= (2*DW)'(sa_d1[i]) * (2*DW)'(sa_d1[i]);
        sb_bb[i] <= (2*DW)'(sa_d1[i]) * (2*DW)'(sa_d2[i]);
        sb_cc[i] <= (2*DW)'(sa_d2[i]) * (2*DW)'(sa_d2[i]);
        sb_dd[i] <= (DW+WW)'(sa_d1[i]) * (DW+WW)'(sa_w0[i]);
        sb_ee[i] <= (DW+WW)'(sa_d2[i]) * (DW+WW)'(sa_w0[i]);
      end
      sb_m[0] <= (2*DW)'(sa_d1[1]) * (2*DW)'(sa_d2[2]);
      sb_m[1] <= (2*DW)'(sa_d1[2]) * (2*DW)'(sa_d2[1]);
      sb_m[2] <= (2*DW)'(sa_d1[2]) * (2*DW)'(sa_d2[0]);
      sb_m[3] <= (2*DW)'(sa_d1[0]) * (2*DW)'(sa_d2[2]);
      sb_m[4] <= (2*DW)'(sa_d1[0]) * (2*DW)'(sa_d2[1]);
      sb_m[5] <= (2*DW)'(sa_d1[1]) * (2*DW)'(sa_d2[0]);
      // C
      sc_d1 <= sb_d1;
      sc_d2 <= sb_d2;
      sc_ps <= sb_ps;
      sc_a  <= AW'(sb_aa[0]) + AW'(sb_aa[1]) + AW'(sb_aa[2]);
      sc_b  <= AW'(sb_bb[0]) + AW'(sb_bb[1]) + AW'(sb_bb[2]);
      sc_c  <= AW'(sb_cc[0]) + AW'(sb_cc[1]) + AW'(sb_cc[2]);
      sc_d  <= DEW'(sb_dd[0]) + DEW'(sb_dd[1]) + DEW'(sb_dd[2]);
      sc_e  <= DEW'(sb_ee[0]) + DEW'(sb_ee[1]) + DEW'(sb_ee[2]);
      for (int i = 0; i < 3; i++) begin
        sc_cr[i] <= CW'(sb_m[2*i]) - CW'(sb_m[2*i+1]);
      end
      // D
      sd_d1 <= sc_d1;
      sd_d2 <= sc_d2;
      sd_ps <= sc_ps;
      for (int i = 0; i < 3; i++) begin
        sd_sq[i] <= DENW'((2*CW)'(sc_cr[i]) * (2*CW)'(sc_cr[i]));
      end
      sd_pp[0] <= mul_hi(sc_e[DEW-1:LOW], sc_b);
      sd_pp[1] <= mul_lo(sc_e[LOW-1:0],   sc_b);
      sd_pp[2] <= mul_hi(sc_d[DEW-1:LOW], sc_c);
      sd_pp[3] <= mul_lo(sc_d[LOW-1:0],   sc_c);
      sd_pp[4] <= mul_hi(sc_e[DEW-1:LOW], sc_a);
      sd_pp[5] <= mul_lo(sc_e[LOW-1:0],   sc_a);
      sd_pp[6] <= mul_hi(sc_d[DEW-1:LOW], sc_b);
      sd_pp[7] <= mul_lo(sc_d[LOW-1:0],   sc_b);
      sd_a  <= sc_a;
      sd_d  <= sc_d;
      sd_zd <= (sc_a == '0);
      // E
      se_d1    <= sd_d1;
      se_d2    <= sd_d2;
      se_ps    <= sd_ps;
      se_denom <= sd_sq[0] + sd_sq[1] + sd_sq[2];
      se_eb    <= join_pp(sd_pp[0], sd_pp[1]);
      se_dc    <= join_pp(sd_pp[2], sd_pp[3]);
      se_ea    <= join_pp(sd_pp[4], sd_pp[5]);
      se_db    <= join_pp(sd_pp[6], sd_pp[7]);
      se_a     <= sd_a;
      se_d     <= sd_d;
      se_zd    <= sd_zd;
      // F: n1 = b*e - c*d, n2 = a*e - b*d
      sf_d1    <= se_d1;
      sf_d2    <= se_d2;
      sf_ps    <= se_ps;
      sf_denom <= se_denom;
      sf_n1    <= se_eb - se_dc;
      sf_n2    <= se_ea - se_db;
      sf_par   <= (se_denom < DENW'(thr)) || (se_denom == '0);
      sf_a     <= se_a;
      sf_d     <= se_d;
      sf_zd    <= se_zd;
      // G: parallel lines use t = -d/a with s = 0; zero D1 forces t = 0
      sg_d1  <= sf_d1;
      sg_d2  <= sf_d2;
      sg_ps  <= sf_ps;
      sg_x   <= sf_zd ? '0 : (sf_par ? -NW'(sf_d) : sf_n1);
      sg_y   <= sf_par ? '0 : sf_n2;
      sg_den <= sf_zd ? DENW'(1) : (sf_par ? DENW'(sf_a) : sf_denom);
      sg_zd  <= sf_zd;
      sg_par <= sf_par;
      // H: top slice carries the sign
      for (int i = 0; i < 3; i++) begin
        sh_pp[i][0]   <= mul_n(signed'({1'b0, sg_x[HLO-1:0]}), sg_d1[i]);
        sh_pp[i][1]   <= mul_n(signed'({1'b0, sg_x[2*HLO-1:HLO]}), sg_d1[i]);
        sh_pp[i][2]   <= mul_n((HLO+1)'(signed'(sg_x[NW-1:2*HLO])), sg_d1[i]);
        sh_pp[i+3][0] <= mul_n(signed'({1'b0, sg_y[HLO-1:0]}), sg_d2[i]);
        sh_pp[i+3][1] <= mul_n(signed'({1'b0, sg_y[2*HLO-1:HLO]}), sg_d2[i]);
        sh_pp[i+3][2] <= mul_n((HLO+1)'(signed'(sg_y[NW-1:2*HLO])), sg_d2[i]);
      end
      sh_den <= sg_den;
      sh_ps  <= sg_ps;
      sh_zd  <= sg_zd;
      sh_par <= sg_par;
      // I
      for (int k = 0; k < 6; k++) begin
        si_num[k] <= (NUMW'(sh_pp[k][2]) <<< (2*HLO)) + (NUMW'(sh_pp[k][1]) <<< HLO)
                     + NUMW'(sh_pp[k][0]);
      end
      si_den <= sh_den;
      si_ps  <= sh_ps;
      si_zd  <= sh_zd;
      si_par <= sh_par;
      // J
      for (int k = 0; k < 6; k++) begin
        sj_mag[k] <= MAGW'(si_num[k][NUMW-1] ? -si_num[k] : si_num[k]);
        sj_neg[k] <= si_num[k][NUMW-1];
      end
      sj_den  <= si_den;
      sj_side <= '{ps: si_ps, par: si_par, zd: si_zd};
      // side data rides alongside the divider
      dly[0] <= sj_side;
      for (int k = 1; k < DIV_LAT; k++) begin
        dly[k] <= dly[k-1];
      end
      // R1: signed offsets
      for (int k = 0; k < 6; k++) begin
        r1_off[k] <= q_neg[k] ? -signed'(OFW'(q_mag[k])) : signed'(OFW'(q_mag[k]));
      end
      r1_side <= dly[DIV_LAT-1];
      // R2: P1 + P2 + t*D1 + s*D2
      for (int i = 0; i < 3; i++) begin
        r2_sum[i] <= SW'(signed'(r1_side.ps[i])) + SW'(r1_off[i]) + SW'(r1_off[i+3]);
      end
      r2_par <= r1_side.par;
      r2_zd  <= r1_side.zd;
      // R3
      for (int i = 0; i < 3; i++) begin
        r3_neg[i] <= r2_sum[i][SW-1];
        r3_mag[i] <= r2_sum[i][SW-1] ? SW'(-r2_sum[i]) : SW'(r2_sum[i]);
      end
      r3_par <= r2_par;
      r3_zd  <= r2_zd;
      // R4: output register, halve with rounding and clip
      for (int i = 0; i < 3; i++) begin
        r4_val[i] <= r4_over[i]
                     ? (r3_neg[i] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}})
                     : (r3_neg[i] ? -PW'(r4_h[i]) : PW'(r4_h[i]));
      end
      saturated      <= r4_over[0] || r4_over[1] || r4_over[2];
      lines_parallel <= r3_par;
      zero_direction <= r3_zd;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      r4_h[i]    = (r3_mag[i] + SW'(1)) >> 1;
      r4_over[i] = r3_neg[i] ? (r4_h[i] > (SW'(1) << (PW-1)))
                             : (r4_h[i] > ((SW'(1) << (PW-1)) - SW'(1)));
    end
  end

  assign mid_x = r4_val[0];
  assign mid_y = r4_val[1];
  assign mid_z = r4_val[2];

  for (genvar k = 0; k < 6; k++) begin : g_lane
    tlcm_div u_div (
      .clk     (clk),
      .adv     (adv),
      .mag     (sj_mag[k]),
      .neg     (sj_neg[k]),
      .den     (sj_den),
      .quo     (q_mag[k]),
      .quo_neg (q_neg[k])
    );
  end

endmodule

/* hw/rtl/tlcm_div.sv */
module tlcm_div (
  input  logic                        clk,
  input  logic                        adv,
  input  logic [tlcm_pkg::MAGW-1:0]   mag,
  input  logic                        neg,
  input  logic [tlcm_pkg::DENW-1:0]   den,
  output logic [tlcm_pkg::QW-1:0]     quo,
  output logic                        quo_neg
);
  import tlcm_pkg::*;

  typedef struct packed {
    logic [DENW-1:0] rem;
    logic [QB-1:0]   low;
    logic [QB-1:0]   q;
    logic [DENW-1:0] den;
    logic            ovf;
    logic            neg;
  } div_st_t;

  div_st_t         st [QB+1];
  logic [DENW-1:0] head_hi;
  logic            fin_up;

  // upper numerator bits; quotient does not fit QB bits when they reach den
  assign head_hi = DENW'(mag[MAGW-1:QB]);

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0].rem <= head_hi;
      st[0].low <= mag[QB-1:0];
      st[0].q   <= '0;
      st[0].den <= den;
      st[0].ovf <= (head_hi >= den);
      st[0].neg <= neg;
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar j = 1; j <= QB; j++) begin : g_bit
    logic [DENW:0] sh;
    logic          ge;
    assign sh = {st[j-1].rem, st[j-1].low[QB-1]};
    assign ge = (sh >= {1'b0, st[j-1].den});
    always_ff @(posedge clk) begin
      if (adv) begin
        st[j].rem <= ge ? DENW'(sh - {1'b0, st[j-1].den}) : DENW'(sh);
        st[j].low <= {st[j-1].low[QB-2:0], 1'b0};
        st[j].q   <= {st[j-1].q[QB-2:0], ge};
        st[j].den <= st[j-1].den;
        st[j].ovf <= st[j-1].ovf;
        st[j].neg <= st[j-1].neg;
      end
    end
  end

  // round half away from zero on the magnitude
  assign fin_up = (st[QB].rem >= (st[QB].den - st[QB].rem));

  always_ff @(posedge clk) begin
    if (adv) begin
      quo     <= st[QB].ovf ? (QW'(1) << QB) : (QW'(st[QB].q) + QW'(fin_up));
      quo_neg <= st[QB].neg;
    end
  end

endmodule

/* bench/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tlcm_pkg::*;

  typedef logic signed [127:0] wide_t;

  // One line pair as offered on the input side.
  typedef struct packed {
    logic signed [PW-1:0] p1x, p1y, p1z;
    logic signed [DW-1:0] d1x, d1y, d1z;
    logic signed [PW-1:0] p2x, p2y, p2z;
    logic signed [DW-1:0] d2x, d2y, d2z;
  } pair_t;

  // One midpoint result.
  typedef struct packed {
    logic signed [PW-1:0] mx, my, mz;
    logic par, zdir, sat;
  } mid_t;

  localparam int    WATCHDOG_LIMIT = 4000;
  localparam int    DRAIN_CYCLES   = 80;
  localparam wide_t POS_MAX = 64'sd2147483647;
  localparam wide_t POS_MIN = -64'sd2147483648;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic threshold_we = 1'b0;
  logic [31:0] threshold_data = '0;
  logic pair_valid = 1'b0;
  logic pair_stall;
  pair_t pair_q = '0;
  logic mid_valid;
  logic mid_stall = 1'b0;
  mid_t mid_o;

  pair_t pending_pairs[$];
  mid_t  expected_mids[$];
  logic [31:0] threshold_model = THRESHOLD_RESET;
  int errors = 0;
  int pairs_in = 0;
  int mids_out = 0;
  int n_par = 0, n_zdir = 0, n_sat = 0;
  bit steady = 1'b0;       // no idling on either side while set
  bit held_off = 1'b0;     // long receiver hold-off already done
  int hold_cnt = 0;
  int quiet_cycles = 0;

  two_line_closest_midpoint_core u_top (
    .clk(clk), .rst(rst),
    .threshold_we(threshold_we), .threshold_data(threshold_data),
    .pair_valid(pair_valid), .pair_stall(pair_stall),
    .first_point_x(pair_q.p1x), .first_point_y(pair_q.p1y),
    .first_point_z(pair_q.p1z),
    .first_dir_x(pair_q.d1x), .first_dir_y(pair_q.d1y), .first_dir_z(pair_q.d1z),
    .second_point_x(pair_q.p2x), .second_point_y(pair_q.p2y),
    .second_point_z(pair_q.p2z),
    .second_dir_x(pair_q.d2x), .second_dir_y(pair_q.d2y), .second_dir_z(pair_q.d2z),
    .mid_valid(mid_valid), .mid_stall(mid_stall),
    .mid_x(mid_o.mx), .mid_y(mid_o.my), .mid_z(mid_o.mz),
    .lines_parallel(mid_o.par), .zero_direction(mid_o.zdir), .saturated(mid_o.sat)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // n / den rounded to nearest, ties away from zero; den > 0
  function automatic wide_t div_round(wide_t n, logic [63:0] den);
    logic [127:0] mag, q, r;
    mag = (n < 0) ? -n : n;
    q = mag / den;
    r = mag % den;
    if ((r << 1) >= den) q = q + 1;
    return (n < 0) ? -q : q;
  endfunction

  // Closest-approach midpoint, exact integer math up to the divisions.
  function automatic mid_t closest_midpoint(pair_t p);
    wide_t p1[3], d1[3], p2[3], d2[3], w0[3];
    wide_t a, b, c, d, e, cx, cy, cz, n1, n2, acc, half;
    logic [63:0] denom;
    mid_t m;
    p1[0] = p.p1x; p1[1] = p.p1y; p1[2] = p.p1z;
    p2[0] = p.p2x; p2[1] = p.p2y; p2[2] = p.p2z;
    d1[0] = p.d1x; d1[1] = p.d1y; d1[2] = p.d1z;
    d2[0] = p.d2x; d2[1] = p.d2y; d2[2] = p.d2z;
    a = 0; b = 0; c = 0; d = 0; e = 0;
    for (int i = 0; i < 3; i++) begin
      w0[i] = p1[i] - p2[i];
      a += d1[i] * d1[i];
      b += d1[i] * d2[i];
      c += d2[i] * d2[i];
      d += d1[i] * w0[i];
      e += d2[i] * w0[i];
    end
    cx = d1[1] * d2[2] - d1[2] * d2[1];
    cy = d1[2] * d2[0] - d1[0] * d2[2];
    cz = d1[0] * d2[1] - d1[1] * d2[0];
    denom = 64'(cx * cx + cy * cy + cz * cz);
    m = '0;
    m.zdir = (a == 0);
    m.par = (denom < {32'd0, threshold_model}) || (denom == 0);
    n1 = e * b - d * c;
    n2 = e * a - d * b;
    for (int i = 0; i < 3; i++) begin
      acc = p1[i] + p2[i];
      if (m.par) begin
        if (!m.zdir) acc += div_round(-(d * d1[i]), 64'(a));
      end else begin
        acc += div_round(n1 * d1[i], denom);
        acc += div_round(n2 * d2[i], denom);
      end
      half = div_round(acc, 64'd2);
      if (half > POS_MAX) begin
        half = POS_MAX; m.sat = 1'b1;
      end else if (half < POS_MIN) begin
        half = POS_MIN; m.sat = 1'b1;
      end
      case (i)
        0: m.mx = half[31:0];
        1: m.my = half[31:0];
        default: m.mz = half[31:0];
      endcase
    end
    return m;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_v);
    errors++;
    $display("MISMATCH %s result %0d: got %0d expected %0d",
             what, mids_out, $signed(got), $signed(exp_v));
  endtask

  // Driver: a transfer happens when valid is high and stall is low; the
  // expectation is formed right then, with the threshold now in force.
  always @(posedge clk) begin
    if (rst) begin
      pair_valid <= 1'b0;
    end else if (!pair_valid || !pair_stall) begin
      if (pair_valid) begin
        expected_mids = {expected_mids, closest_midpoint(pair_q)};
        pairs_in++;
      end
      if (pending_pairs.size() > 0 && (steady || $urandom_range(0, 99) >= 7)) begin
        pair_q <= pending_pairs.pop_front();
        pair_valid <= 1'b1;
      end else begin
        pair_valid <= 1'b0;
      end
    end
  end

  // Receiver stall: random, plus one long hold-off so the pipe backs up.
  always @(posedge clk) begin
    if (rst) begin
      mid_stall <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      mid_stall <= 1'b1;
    end else if (!held_off && pairs_in >= 400) begin
      held_off <= 1'b1;
      hold_cnt <= 300;
      mid_stall <= 1'b1;
    end else begin
      mid_stall <= !steady && ($urandom_range(0, 99) < 7);
    end
  end

  // Monitor: each result transfer is checked against the oldest expectation.
  always @(posedge clk) begin
    mid_t exp_m;
    if (!rst && mid_valid && !mid_stall) begin
      if (expected_mids.size() == 0) begin
        report_mismatch("unexpected", mid_o.mx, 32'd0);
      end else begin
        exp_m = expected_mids.pop_front();
        if (mid_o.mx !== exp_m.mx) report_mismatch("mid_x", mid_o.mx, exp_m.mx);
        if (mid_o.my !== exp_m.my) report_mismatch("mid_y", mid_o.my, exp_m.my);
        if (mid_o.mz !== exp_m.mz) report_mismatch("mid_z", mid_o.mz, exp_m.mz);
        if (mid_o.par !== exp_m.par)
          report_mismatch("lines_parallel", 32'(mid_o.par), 32'(exp_m.par));
        if (mid_o.zdir !== exp_m.zdir)
          report_mismatch("zero_direction", 32'(mid_o.zdir), 32'(exp_m.zdir));
        if (mid_o.sat !== exp_m.sat)
          report_mismatch("saturated", 32'(mid_o.sat), 32'(exp_m.sat));
        n_par += exp_m.par;
        n_zdir += exp_m.zdir;
        n_sat += exp_m.sat;
      end
      mids_out++;
    end
  end

  // Watchdog: stretch of cycles with no transfer on either side.
  always @(posedge clk) begin
    if (rst || (pair_valid && !pair_stall) || (mid_valid && !mid_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [31:0] pick_pos(int kind);
    case (kind)
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'd0;
      3: return 32'hFFFFFFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_dir(int kind);
    case (kind)
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'd0;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] near_pos();
    return 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
  endfunction

  // Random pair: mostly well-posed geometry, some near-parallel and
  // degenerate directions, some full-range noise and corner values.
  function automatic pair_t random_pair();
    pair_t p;
    int kind;
    kind = $urandom_range(0, 99);
    p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom};
    if (kind < 70) begin
      p.p1x = near_pos(); p.p1y = near_pos(); p.p1z = near_pos();
      p.p2x = near_pos(); p.p2y = near_pos(); p.p2z = near_pos();
    end
    if (kind >= 50 && kind < 62) begin
      // nearly the same direction, so denom is tiny
      p.d2x = p.d1x + 16'($urandom_range(0, 6)) - 16'd3;
      p.d2y = p.d1y + 16'($urandom_range(0, 6)) - 16'd3;
      p.d2z = p.d1z + 16'($urandom_range(0, 6)) - 16'd3;
    end else if (kind >= 62 && kind < 70) begin
      p.d1x = '0; p.d1y = '0; p.d1z = '0;
      if (kind == 69) begin
        p.d2x = '0; p.d2y = '0; p.d2z = '0;
      end
    end else if (kind >= 80) begin
      p.p1x = pick_pos($urandom_range(0, 5)); p.p1y = pick_pos($urandom_range(0, 5));
      p.p1z = pick_pos($urandom_range(0, 5)); p.p2x = pick_pos($urandom_range(0, 5));
      p.p2y = pick_pos($urandom_range(0, 5)); p.p2z = pick_pos($urandom_range(0, 5));
      p.d1x = pick_dir($urandom_range(0, 5)); p.d1y = pick_dir($urandom_range(0, 5));
      p.d1z = pick_dir($urandom_range(0, 5)); p.d2x = pick_dir($urandom_range(0, 5));
      p.d2y = pick_dir($urandom_range(0, 5)); p.d2z = pick_dir($urandom_range(0, 5));
    end
    return p;
  endfunction

  task automatic queue_pair(pair_t p);
    pending_pairs = {pending_pairs, p};
  endtask

  task automatic add_pair(logic [31:0] p1x, p1y, p1z, logic [15:0] d1x, d1y, d1z,
                          logic [31:0] p2x, p2y, p2z, logic [15:0] d2x, d2y, d2z);
    queue_pair({p1x, p1y, p1z, d1x, d1y, d1z, p2x, p2y, p2z, d2x, d2y, d2z});
  endtask

  // Wait until the pipe is empty, then let it settle before a register write.
  task automatic drain();
    while (pending_pairs.size() != 0 || pair_valid || expected_mids.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_threshold(logic [31:0] value);
    drain();
    threshold_we <= 1'b1;
    threshold_data <= value;
    @(posedge clk);
    threshold_we <= 1'b0;
    threshold_model = value;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: corners, zero directions, parallel and skew lines, rounding.
    add_pair('0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0);
    add_pair(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
             32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    add_pair(32'h80000000, 32'h80000000, 32'h80000000, 16'h8000, 16'h8000, 16'h8000,
             32'h80000000, 32'h80000000, 32'h80000000, 16'h8000, 16'h8000, 16'h8000);
    // skew: x axis and y axis, 10 apart in z
    add_pair('0, '0, '0, 16'h4000, '0, '0, 32'd2560, 32'd512, 32'd2560, '0, 16'h4000, '0);
    add_pair(32'd256, 32'd0, 32'd0, 16'h4000, 16'h4000, '0,
             32'd0, 32'd256, 32'd1024, 16'hC000, 16'h4000, 16'h2000);
    // identical and antiparallel directions
    add_pair(32'd1000, 32'd2000, 32'd3000, 16'h1234, 16'h2345, 16'h0456,
             32'd7000, 32'hFFFFF000, 32'd9, 16'h1234, 16'h2345, 16'h0456);
    add_pair(32'd1000, 32'd2000, 32'd3000, 16'h1234, 16'h2345, 16'h0456,
             32'd7000, 32'hFFFFF000, 32'd9, 16'hEDCC, 16'hDCBB, 16'hFBAA);
    // zero first direction, ties in the halving
    add_pair(32'd1, 32'hFFFFFFFF, 32'd3, '0, '0, '0, '0, '0, '0, 16'h4000, '0, '0);
    add_pair(32'd1, 32'hFFFFFFFF, 32'd5, '0, '0, '0, '0, '0, '0, '0, '0, '0);
    add_pair(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, '0, '0, '0,
             32'h7FFFFFFF, 32'h80000000, 32'd0, 16'h7FFF, 16'h8000, 16'd1);
    // nearly parallel, huge offsets: saturation
    add_pair(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
             32'h80000000, 32'h7FFFFFFF, 32'h80000000, 16'h7FFF, 16'h7FFF, 16'h7FFE);
    add_pair(32'h80000000, 32'h80000000, 32'h80000000, 16'h8000, '0, '0,
             32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h8000, 16'd1, '0);
    add_pair(32'h7FFFFFFF, '0, '0, 16'd1, '0, '0, 32'h80000000, '0, '0, 16'h7FFF, '0, '0);
    add_pair(32'd300, 32'd300, 32'd300, 16'd1, 16'd1, 16'd1,
             32'hFFFFFED4, 32'd0, 32'd0, 16'hFFFF, 16'd1, 16'd0);
    for (int i = 0; i < 300; i++) queue_pair(random_pair());

    // Nothing below threshold except exact zero; includes the long hold-off.
    set_threshold(32'd0);
    for (int i = 0; i < 300; i++) queue_pair(random_pair());

    // Threshold at its maximum, at full rate with no idling.
    set_threshold(32'hFFFFFFFF);
    steady = 1'b1;
    for (int i = 0; i < 300; i++) queue_pair(random_pair());

    set_threshold($urandom);
    drain();
    steady = 1'b0;
    for (int i = 0; i < 250; i++) queue_pair(random_pair());

    set_threshold(THRESHOLD_RESET);
    for (int i = 0; i < 280; i++) queue_pair(random_pair());

    drain();
    $display("Covered %0d line pairs over five thresholds: %0d parallel, %0d zero first",
             mids_out, n_par, n_zdir);
    $display("direction, %0d saturated, with one long output hold-off.", n_sat);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
